@@ design/complete_tree_inorder_walk_defines.svh @@
// ---------------------------------------------------------------------------
// complete tree inorder walk: assertion macros
// shared concurrent assertion forms, clocked on clk and idle during rst
// ---------------------------------------------------------------------------
`ifndef COMPLETE_TREE_INORDER_WALK_DEFINES_SVH
`define COMPLETE_TREE_INORDER_WALK_DEFINES_SVH

// same-cycle implication
`define CTW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ctw assertion failed");

// next-cycle implication
`define CTW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ctw assertion failed");

`endif

@@ design/ctw_pkg.sv @@
// ---------------------------------------------------------------------------
// ctw_pkg
// constants, types and codes shared by the tree walk modules
// ---------------------------------------------------------------------------
package ctw_pkg;

  localparam int CAPACITY    = 64;
  localparam int STORE_DEPTH = 64;
  localparam int STORE_AW    = 6;
  localparam int STACK_DEPTH = 7;
  localparam int TOP_W       = 3;
  localparam int COUNT_W     = 7;
  localparam int CUR_W       = 8;
  localparam int SYM_W       = 8;

  localparam logic CMD_INSERT   = 1'b0;
  localparam logic CMD_TRAVERSE = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } ctw_state_t;

  typedef struct packed {
    logic insert;
    logic init;
    logic push;
    logic pop;
  } ctw_cmd_t;

  typedef struct packed {
    logic cur_in_tree;
    logic stack_empty;
    logic full;
  } ctw_stat_t;

endpackage

@@ design/ctw_ram.sv @@
// ---------------------------------------------------------------------------
// ctw_ram
// generic single write, single read memory with registered read data
// ---------------------------------------------------------------------------
module ctw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/ctw_ctrl.sv @@
// ---------------------------------------------------------------------------
// ctw_ctrl
// command decode and walk sequencing: push steps while the cursor is in the tree, else pop steps
// ---------------------------------------------------------------------------
module ctw_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              command,
  input  ctw_pkg::ctw_stat_t stat,
  output ctw_pkg::ctw_cmd_t  cmd,
  output logic              busy
);

  import ctw_pkg::*;

  ctw_state_t state;
  ctw_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start && command == CMD_TRAVERSE) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!stat.cur_in_tree && stat.stack_empty) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    unique case (state)
      ST_IDLE: begin
        cmd.insert = start && command == CMD_INSERT && !stat.full;
        cmd.init   = start && command == CMD_TRAVERSE;
      end
      ST_WALK: begin
        busy     = 1'b1;
        cmd.push = stat.cur_in_tree;
        cmd.pop  = !stat.cur_in_tree && !stat.stack_empty;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

@@ design/ctw_dp.sv @@
// ---------------------------------------------------------------------------
// ctw_dp
// node store, node count, walk stack, cursor and result registers
// ---------------------------------------------------------------------------
`include "complete_tree_inorder_walk_defines.svh"

module ctw_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  ctw_pkg::ctw_cmd_t          cmd,
  input  logic [ctw_pkg::SYM_W-1:0] symbol,
  output ctw_pkg::ctw_stat_t         stat,
  output logic [ctw_pkg::SYM_W-1:0] out_symbol,
  output logic                      last,
  output logic                      strobe
);

  import ctw_pkg::*;

  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  emitted;
  logic [CUR_W-1:0]    cur;
  logic [TOP_W-1:0]    top;
  logic [STORE_AW-1:0] stack [STACK_DEPTH];
  logic [STORE_AW-1:0] popped;
  logic [TOP_W-1:0]    top_dec;

  assign top_dec = top - TOP_W'(1);
  assign popped  = stack[top_dec];

  assign stat.full        = count >= COUNT_W'(CAPACITY);
  assign stat.stack_empty = top == '0;
  assign stat.cur_in_tree = (cur < {1'b0, count}) && (top != TOP_W'(STACK_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      strobe <= 1'b0;
    end else begin
      if (cmd.insert) begin
        count <= count + COUNT_W'(1);
      end
      strobe <= cmd.pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      cur     <= '0;
      top     <= '0;
      emitted <= '0;
    end else if (cmd.push) begin
      stack[top] <= cur[STORE_AW-1:0];
      top        <= top + TOP_W'(1);
      cur        <= {cur[CUR_W-2:0], 1'b1};
    end else if (cmd.pop) begin
      top     <= top_dec;
      cur     <= {1'b0, popped, 1'b0} + CUR_W'(2);
      emitted <= emitted + COUNT_W'(1);
      last    <= (emitted + COUNT_W'(1)) == count;
    end
  end

  ctw_ram #(
    .WIDTH (SYM_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.insert),
    .waddr (count[STORE_AW-1:0]),
    .wdata (symbol),
    .re    (cmd.pop),
    .raddr (popped),
    .rdata (out_symbol)
  );

  `CTW_ASSERT_NOW(a_push_room, cmd.push, top < TOP_W'(STACK_DEPTH))
  `CTW_ASSERT_NOW(a_pop_nonempty, cmd.pop, top != '0)
  `CTW_ASSERT_NOW(a_count_bound, 1'b1, count <= COUNT_W'(CAPACITY))
  `CTW_ASSERT_NEXT(a_pop_gives_word, cmd.pop, strobe)
  `CTW_ASSERT_NEXT(a_nothing_after_last, strobe && last, !strobe)

endmodule

@@ design/complete_tree_inorder_walk.sv @@
// ---------------------------------------------------------------------------
// complete_tree_inorder_walk
// level-order complete binary tree of byte symbols with inorder readout
//
//   channel   handshake              words
//   command   start / busy           command, symbol
//   result    strobe                 out_symbol, last
//
// a full store drops an insert
// a traverse holds busy through the walk: the walk stack takes one
// push or one pop per cycle, and each pop gives one word in the cycle after it
// an empty tree gives no word and frees the block
// rst clears the node count, so the tree starts empty; results cannot stall
// ---------------------------------------------------------------------------
module complete_tree_inorder_walk (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic                      command,
  input  logic [ctw_pkg::SYM_W-1:0] symbol,
  output logic [ctw_pkg::SYM_W-1:0] out_symbol,
  output logic                      last,
  output logic                      strobe
);

  import ctw_pkg::*;

  ctw_cmd_t  cmd;
  ctw_stat_t stat;

  ctw_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  ctw_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .symbol     (symbol),
    .stat       (stat),
    .out_symbol (out_symbol),
    .last       (last),
    .strobe     (strobe)
  );

endmodule

@@ tb/tb_complete_tree_inorder_walk.sv @@
// ---------------------------------------------------------------------------
// tb_complete_tree_inorder_walk
// drives insert and traverse commands into the tree walk block and checks
// every output word against a level-order tree model walked in inorder
// ---------------------------------------------------------------------------
module tb_complete_tree_inorder_walk;
  import ctw_pkg::*;

  typedef struct packed {
    logic             cmd;
    logic [SYM_W-1:0] sym;
    logic             drain;
  } command_item_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             last;
  } walk_word_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             command = CMD_INSERT;
  logic [SYM_W-1:0] symbol = '0;
  logic             busy;
  logic [SYM_W-1:0] out_symbol;
  logic             last;
  logic             strobe;

  command_item_t    pending_cmds [$];
  walk_word_t       due_words [$];
  logic [SYM_W-1:0] tree_symbols [CAPACITY];
  int               tree_size = 0;
  int               accepted_cmds = 0;
  int               fails = 0;

  complete_tree_inorder_walk u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .command    (command),
    .symbol     (symbol),
    .out_symbol (out_symbol),
    .last       (last),
    .strobe     (strobe)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // tree model: insert grows the level-order array unless full, traverse queues the inorder words
  task automatic apply_to_tree(input logic cmd, input logic [SYM_W-1:0] sym);
    int         path [$];
    int         cur;
    int         emitted;
    walk_word_t w;
    if (cmd == CMD_INSERT) begin
      if (tree_size < CAPACITY) begin
        tree_symbols[tree_size] = sym;
        tree_size++;
      end
    end else begin
      cur = 0;
      emitted = 0;
      while (cur < tree_size || path.size() > 0) begin
        while (cur < tree_size) begin
          path.push_back(cur);
          cur = 2 * cur + 1;
        end
        cur = path.pop_back();
        emitted++;
        w.sym = tree_symbols[cur];
        w.last = (emitted == tree_size);
        due_words.push_back(w);
        cur = 2 * cur + 2;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin
    command_item_t nxt;
    logic          took;
    logic          gap;
    took = start && !busy;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (took) begin
        apply_to_tree(command, symbol);
        accepted_cmds++;
      end
      if (!start || took) begin
        gap = ($urandom_range(0, 99) < 36) && !(accepted_cmds >= 100 && accepted_cmds < 250);
        if (pending_cmds.size() > 0 && !gap &&
            !(pending_cmds[0].drain && due_words.size() > 0)) begin
          nxt = pending_cmds.pop_front();
          start <= 1'b1;
          command <= nxt.cmd;
          symbol <= nxt.sym;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    walk_word_t w;
    if (!rst && strobe) begin
      if (due_words.size() == 0) begin
        $error("unexpected word: out_symbol %0h last %0b", out_symbol, last);
        fails++;
      end else begin
        w = due_words.pop_front();
        if (out_symbol !== w.sym) begin
          $error("out_symbol expected %0h actual %0h", w.sym, out_symbol);
          fails++;
        end
        if (last !== w.last) begin
          $error("last expected %0b actual %0b", w.last, last);
          fails++;
        end
      end
    end
  end

  task automatic add_cmd(input logic cmd, input logic [SYM_W-1:0] sym,
                         input logic drain);
    command_item_t c;
    c.cmd = cmd;
    c.sym = sym;
    c.drain = drain;
    pending_cmds.push_back(c);
  endtask

  initial begin
    int counted;
    logic cmd;
    counted = 0;

    // directed: empty walk, one to a handful of nodes, extreme symbols
    add_cmd(CMD_TRAVERSE, 8'hff, 1'b0);
    add_cmd(CMD_INSERT, 8'h00, 1'b0);
    add_cmd(CMD_TRAVERSE, 8'h00, 1'b0);
    add_cmd(CMD_INSERT, 8'hff, 1'b0);
    add_cmd(CMD_TRAVERSE, 8'h5a, 1'b1);
    add_cmd(CMD_INSERT, 8'h55, 1'b0);
    add_cmd(CMD_TRAVERSE, 8'h00, 1'b0);
    add_cmd(CMD_INSERT, 8'haa, 1'b0);
    add_cmd(CMD_INSERT, 8'h01, 1'b0);
    add_cmd(CMD_TRAVERSE, 8'h00, 1'b0);
    add_cmd(CMD_INSERT, 8'h80, 1'b0);
    add_cmd(CMD_INSERT, 8'h7f, 1'b0);
    add_cmd(CMD_TRAVERSE, 8'hff, 1'b0);
    add_cmd(CMD_TRAVERSE, 8'h00, 1'b1);
    counted = 14;

    // random: tree fills to capacity, then inserts when full are dropped
    while (counted < 500) begin
      cmd = ($urandom_range(0, 99) < 40) ? CMD_INSERT : CMD_TRAVERSE;
      add_cmd(cmd, SYM_W'($urandom_range(0, 255)), $urandom_range(0, 99) < 3);
      counted++;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_cmds.size() > 0 || start) @(posedge clk);
    while (due_words.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fails == 0 && due_words.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/ctw_pkg.sv
design/ctw_ram.sv
design/ctw_ctrl.sv
design/ctw_dp.sv
design/complete_tree_inorder_walk.sv
tb/tb_complete_tree_inorder_walk.sv
